// ===== src/sha256_pkg.sv =====
// SHA-256 shared package: round constants, initial chaining values, helpers.
// Used by every module of the hash core; no dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned NumRounds  = 64;
	localparam int unsigned FifoDepth  = 4;

	typedef logic [31:0] word_t;

	// front-to-back command
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} cmd_t;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== src/sha256_if.sv =====
// Valid/ready channel interfaces for the hash core.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        final_word;
	modport source (output valid, digest_word, word_index, final_word, input ready);
	modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

// ===== src/sha256_hash_core.sv =====
// Top level of the SHA-256 hash core: front queue plus hash engine.
// Depends on sha256_pkg, sha256_if, sha256_fifo, sha256_engine.
`timescale 1ns / 1ps
// Channel | Dir | Beat content
// in      | in  | msg_byte, byte_present, end_of_message
// out     | out | digest_word, word_index, final_word
//
// A byte beat is queued and absorbed once the engine is idle; every 64th
// byte costs 64 rounds plus a fold step in the single round unit.
// Closing a message adds a padding step, 64 rounds and a fold step, twice
// when the marker lands at byte 56 or later, then eight output beats.
// Reset restores the standard initial hash values. The input queue keeps
// accepting while the engine compresses or the output side stalls, until
// its four entries are full.
module sha256_hash_core
	import sha256_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha256_in_if.sink    in,
	sha256_out_if.source out
);
	cmd_t push_cmd, pop_cmd;
	logic full, empty, pop;

	assign push_cmd = '{msg_byte: in.msg_byte, byte_present: in.byte_present,
		end_of_message: in.end_of_message};
	// queue every beat; the engine drops beats with no byte and no close
	assign in.ready = !full;

	sha256_fifo u_fifo (
		.clk, .arst_n,
		.push(in.valid), .push_cmd, .full,
		.pop, .pop_cmd, .empty
	);

	sha256_engine u_engine (
		.clk, .arst_n,
		.cmd_valid(!empty), .cmd(pop_cmd), .cmd_pop(pop),
		.out_valid(out.valid), .out_ready(out.ready),
		.out_word(out.digest_word), .out_index(out.word_index),
		.out_final(out.final_word)
	);
endmodule

// ===== src/sha256_fifo.sv =====
// Short command queue between the front (accept) and back (hash engine).
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_fifo
	import sha256_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);
	localparam int unsigned AddrW = $clog2(FifoDepth);

	cmd_t             mem_q [FifoDepth];
	logic [AddrW-1:0] wr_q, rd_q;
	logic [AddrW:0]   cnt_q;

	assign full    = (cnt_q == (AddrW+1)'(FifoDepth));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AddrW+1)'(push && !full) - (AddrW+1)'(pop && !empty);
		end
	end
endmodule

// ===== src/sha256_engine.sv =====
// Back end: absorbs bytes into a block, pads, runs 64 rounds, emits digest.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_engine
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_index,
	output logic        out_final
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StComp = 3'd1;
	localparam logic [2:0] StPad  = 3'd2;
	localparam logic [2:0] StEmit = 3'd3;
	localparam logic [2:0] StFold = 3'd4;

	logic [2:0]  st_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];  // block buffer while filling, schedule window while compressing
	logic [5:0]  rnd_q;
	logic        fin_q;     // compress belongs to message close
	logic        last_q;    // current compress is the final one
	logic        mark_q;    // next padding block still needs the 0x80 marker
	logic [5:0]  pos_q;     // byte position of the marker
	logic [2:0]  idx_q;

	word_t s0, s1, t1, t2, ch, mj, w_nx;
	word_t v_nx [8];
	logic [5:0] n_eff;

	always_comb begin
		// window holds w[t..t+15]; build w[t+16] beside the round
		w_nx = w_q[0] + (ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9]
			+ (ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10));
		s1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + round_k(rnd_q) + w_q[0];
		s0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
		v_nx[0] = t1 + t2;
		v_nx[1] = v_q[0];
		v_nx[2] = v_q[1];
		v_nx[3] = v_q[2];
		v_nx[4] = v_q[3] + t1;
		v_nx[5] = v_q[4];
		v_nx[6] = v_q[5];
		v_nx[7] = v_q[6];
		n_eff = fill_q + 6'(cmd.byte_present);
	end

	assign cmd_pop   = (st_q == StIdle) && cmd_valid;
	assign out_valid = (st_q == StEmit);
	assign out_word  = h_q[idx_q];
	assign out_index = idx_q;
	assign out_final = (idx_q == 3'd7);

	// payload: block bytes, padding and schedule window
	always_ff @(posedge clk) begin
		if (st_q == StIdle) begin
			if (cmd_valid && cmd.byte_present)
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= cmd.msg_byte;
		end else if (st_q == StPad) begin
			for (int j = 0; j < BlockBytes; j++) begin
				if (last_q && j >= 56)
					w_q[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= bits_q[8*(63-j) +: 8];
				else if (mark_q && 6'(j) == pos_q)
					w_q[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= 8'h80;
				else if (!mark_q || 6'(j) > pos_q)
					w_q[4'(j >> 2)][8*(3 - (j & 3)) +: 8] <= 8'h00;
			end
		end else if (st_q == StComp) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= StIdle;
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
			fin_q  <= 1'b0;
			last_q <= 1'b0;
			mark_q <= 1'b0;
			pos_q  <= '0;
			idx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_h(3'(i));
				v_q[i] <= init_h(3'(i));
			end
		end else begin
			unique case (st_q)
				StIdle: if (cmd_valid) begin
					if (cmd.byte_present && fill_q == 6'd63) begin
						// block full: compress, close later if asked
						fill_q <= '0;
						bits_q <= bits_q + 64'd512;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						rnd_q  <= '0;
						fin_q  <= cmd.end_of_message;
						last_q <= 1'b0;
						mark_q <= 1'b1;
						pos_q  <= '0;
						st_q   <= StComp;
					end else if (cmd.end_of_message) begin
						// marker goes right after the last byte; length fits if it lands before 56
						fill_q <= '0;
						bits_q <= bits_q + {55'd0, n_eff, 3'd0};
						mark_q <= 1'b1;
						pos_q  <= n_eff;
						last_q <= (n_eff < 6'd56);
						st_q   <= StPad;
					end else if (cmd.byte_present) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				StComp: begin
					for (int i = 0; i < 8; i++) v_q[i] <= v_nx[i];
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'(NumRounds-1)) st_q <= StFold;
				end
				StFold: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (last_q) begin
						idx_q <= '0;
						st_q  <= StEmit;
					end else if (fin_q) begin
						last_q <= 1'b1;
						st_q   <= StPad;
					end else st_q <= StIdle;
				end
				StPad: begin
					// buffer writes happen in the payload block; then compress
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					rnd_q  <= '0;
					mark_q <= 1'b0;
					fin_q  <= 1'b1;
					st_q   <= StComp;
				end
				StEmit: if (out_ready) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
						fill_q <= '0;
						bits_q <= '0;
						fin_q  <= 1'b0;
						last_q <= 1'b0;
						st_q   <= StIdle;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end
endmodule

// ===== tb/sha256_hash_core_tb.sv =====
// Self-checking testbench for the SHA-256 hash core: byte beats in, digest beats out.
// Depends on sha256_pkg, sha256_if and sha256_hash_core; a built-in predictor checks results.
`timescale 1ns / 1ps
module sha256_hash_core_tb;
	import sha256_pkg::*;

	logic clk;
	logic arst_n;

	sha256_in_if  in_ch();
	sha256_out_if out_ch();

	sha256_hash_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	// One expected digest beat.
	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       final_word;
	} digest_beat_t;

	// One row of the directed stimulus. When has_digest is set, the first digest word
	// of the closing row is also checked against a known value.
	typedef struct {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
		logic       has_digest;
		word_t      digest0;
	} stim_row_t;

	// Predictor state: chaining words, block buffer, fill level and bit count.
	word_t       hash_h[8];
	logic [7:0]  blk[64];
	int unsigned fill;
	logic [63:0] done_bits;

	digest_beat_t digest_q[$];
	int           errors = 0;
	longint       cycle_cnt = 0;
	int           sent_cnt = 0;
	logic         quiet = 1'b0;   // when set, neither side idles

	localparam longint CycleLimit = 64'd2_000_000;

	// Generate a clock with an 8 ns period.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Count cycles and end the run on a hang.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Restore the chaining words to the initial values and clear the message state.
	function automatic void hash_restart();
		for (int i = 0; i < 8; i++)
			hash_h[i] = init_h(i[2:0]);
		fill = 0;
		done_bits = '0;
	endfunction

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run the 64 rounds over blk and fold the result into hash_h.
	function automatic void compress();
		word_t w[64];
		word_t v[8];
		word_t t1;
		word_t t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
		for (int t = 0; t < 8; t++)
			v[t] = hash_h[t];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++)
			hash_h[t] += v[t];
	endfunction

	// Absorb one beat; on a closing beat pad, finish and queue the eight digest words.
	function automatic void hash_beat(logic [7:0] b, logic present, logic last);
		logic [63:0]  total;
		int unsigned  n;
		digest_beat_t d;
		if (present) begin
			blk[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				done_bits += 64'd512;
				fill = 0;
			end
		end
		if (!last)
			return;
		n = fill;
		total = done_bits + 64'(n) * 8;
		blk[n] = 8'h80;
		n++;
		if (n > 56) begin
			while (n < 64) begin
				blk[n] = 8'h00;
				n++;
			end
			compress();
			n = 0;
		end
		while (n < 56) begin
			blk[n] = 8'h00;
			n++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = total[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_h[i];
			d.word_index  = i[2:0];
			d.final_word  = (i == 7);
			digest_q = {digest_q, d};
		end
		hash_restart();
	endfunction

	// Drive one beat, holding it until it is accepted; idle first at random.
	// Valid stays high after acceptance; the caller drops it before waiting.
	task automatic send_beat(logic [7:0] b, logic present, logic last);
		quiet = (sent_cnt >= 200 && sent_cnt < 300);
		while (!quiet && $urandom_range(99) < 12) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.msg_byte       <= b;
		in_ch.byte_present   <= present;
		in_ch.end_of_message <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		hash_beat(b, present, last);
		sent_cnt++;
	endtask

	// Stall the output side at random, except during quiet stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= quiet || ($urandom_range(99) >= 12);
		end
	end

	// Compare each accepted digest beat with the oldest expectation.
	always @(posedge clk) begin
		digest_beat_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_q.size() == 0) begin
				$error("digest beat with nothing expected: %h", out_ch.digest_word);
				errors++;
			end else begin
				e = digest_q.pop_front();
				if (out_ch.digest_word !== e.digest_word) begin
					$error("digest_word expected %h got %h", e.digest_word, out_ch.digest_word);
					errors++;
				end
				if (out_ch.word_index !== e.word_index) begin
					$error("word_index expected %0d got %0d", e.word_index, out_ch.word_index);
					errors++;
				end
				if (out_ch.final_word !== e.final_word) begin
					$error("final_word expected %0d got %0d", e.final_word, out_ch.final_word);
					errors++;
				end
			end
		end
	end

	stim_row_t rows[$];

	task automatic add_row(logic [7:0] b, logic p, logic l, logic hd, word_t d0);
		stim_row_t r;
		r.msg_byte = b; r.byte_present = p; r.end_of_message = l;
		r.has_digest = hd; r.digest0 = d0;
		rows = {rows, r};
	endtask

	initial begin
		int          len;
		int          wait_cnt;
		logic [7:0]  b;
		logic        is_last;
		stim_row_t   r;

		arst_n    = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.msg_byte       = 8'h00;
		in_ch.byte_present   = 1'b0;
		in_ch.end_of_message = 1'b0;
		hash_restart();
		for (int i = 0; i < 64; i++)
			blk[i] = 8'h00;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty message right after reset, a no-op beat, "abc",
		// byte with end, extreme bytes and an empty close after bytes.
		add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
		add_row(8'h5a, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
		add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
		add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf);
		add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
		add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
		add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);

		foreach (rows[i]) begin
			r = rows[i];
			send_beat(r.msg_byte, r.byte_present, r.end_of_message);
			// Expected first word is typed in; check the predictor agrees with it.
			if (r.has_digest && digest_q.size() >= 8
				&& digest_q[digest_q.size()-8].digest_word !== r.digest0) begin
				$error("digest_word expected %h got %h", r.digest0,
					digest_q[digest_q.size()-8].digest_word);
				errors++;
			end
		end

		// Message lengths around the padding boundaries: 55, 56, 63, 64 and 119 bytes.
		for (int k = 0; k < 5; k++) begin
			len = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : (k == 3) ? 64 : 119;
			for (int i = 0; i < len; i++)
				send_beat(8'($urandom_range(255)), 1'b1, i == len - 1);
		end

		// Hold off until every digest has drained.
		in_ch.valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);

		// Random messages: mostly short, a few past one block; no-op beats sprinkled in.
		while (sent_cnt < 410) begin
			len = ($urandom_range(9) == 0) ? int'($urandom_range(130))
				: int'($urandom_range(20));
			if (len > 410 - sent_cnt)
				len = 410 - sent_cnt;
			for (int i = 0; i <= len; i++) begin
				is_last = (i == len);
				b = 8'($urandom_range(255));
				if ($urandom_range(15) == 0)
					send_beat(b, 1'b0, 1'b0);
				if (is_last && $urandom_range(3) == 0)
					send_beat(b, 1'b0, 1'b1);
				else
					send_beat(b, 1'b1, is_last);
			end
		end
		in_ch.valid <= 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		wait_cnt = 0;
		while (wait_cnt < 200) begin
			@(posedge clk);
			wait_cnt++;
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
